/* hdl/ppcf_pkg.sv */
`default_nettype none

package ppcf_pkg;

  // Width of the working displacement. Tilt and length corrections can push
  // a component well past 33 bits.
  localparam int DW = 40;

  // Configuration register indexes
  localparam logic [2:0] CFG_BOX_X  = 3'd0;
  localparam logic [2:0] CFG_BOX_Y  = 3'd1;
  localparam logic [2:0] CFG_BOX_Z  = 3'd2;
  localparam logic [2:0] CFG_TILT_XY = 3'd3;
  localparam logic [2:0] CFG_TILT_YZ = 3'd4;
  localparam logic [2:0] CFG_TILT_XZ = 3'd5;
  localparam logic [2:0] CFG_CUTOFF = 3'd6;

  // Multiplier operand selects
  localparam logic [1:0] SQ_CUT = 2'd0;
  localparam logic [1:0] SQ_X   = 2'd1;
  localparam logic [1:0] SQ_Y   = 2'd2;
  localparam logic [1:0] SQ_Z   = 2'd3;

  typedef struct packed {
    logic [15:0]        first_index;
    logic [15:0]        second_index;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic               restart_count;
  } pair_in_t;

  typedef struct packed {
    logic [15:0] pair_first;
    logic [15:0] pair_second;
    logic [31:0] pair_ordinal;
    logic        wrap_overflow;
  } pair_out_t;

  typedef struct packed {
    logic [30:0]        box_x;
    logic [30:0]        box_y;
    logic [30:0]        box_z;
    logic signed [31:0] tilt_xy;
    logic signed [31:0] tilt_yz;
    logic signed [31:0] tilt_xz;
    logic [30:0]        cutoff;
  } cfg_t;

  typedef enum logic [1:0] {
    AX_Z,
    AX_Y,
    AX_X
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP_Z,
    ST_WRAP_Y,
    ST_WRAP_X,
    ST_RANGE,
    ST_SQUARE,
    ST_SETTLE,
    ST_COMPARE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        load;
    logic        correct;
    axis_t       axis;
    logic        set_ovf;
    logic        square;
    logic [1:0]  sq_sel;
    logic        emit;
  } cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic fits_z;
    logic fits_y;
    logic fits_x;
    logic out_of_range;
    logic in_cutoff;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* hdl/ppcf_ctrl.sv */
`default_nettype none

module ppcf_ctrl #(
  parameter int WRAP_LIMIT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ppcf_pkg::status_t status,
  output ppcf_pkg::cmd_t         cmd
);
  import ppcf_pkg::*;

  localparam int WCW = $clog2(WRAP_LIMIT + 1);
  localparam logic [WCW-1:0] WrapMax = WCW'(WRAP_LIMIT);

  state_t         state, state_next;
  logic [WCW-1:0] wrap_n, wrap_n_next;
  logic [1:0]     step, step_next;
  logic           limit;
  logic           fits_now;

  assign limit = (wrap_n == WrapMax);

  always_comb begin
    case (state)
      ST_WRAP_Z: fits_now = status.fits_z;
      ST_WRAP_Y: fits_now = status.fits_y;
      ST_WRAP_X: fits_now = status.fits_x;
      default:   fits_now = 1'b1;
    endcase
  end

  // Next state and counters
  always_comb begin
    state_next  = state;
    wrap_n_next = wrap_n;
    step_next   = step;
    case (state)
      ST_IDLE: begin
        wrap_n_next = '0;
        step_next   = '0;
        if (in_valid && status.pair_ok) begin
          state_next = ST_WRAP_Z;
        end
      end
      ST_WRAP_Z, ST_WRAP_Y, ST_WRAP_X: begin
        if (fits_now || limit) begin
          wrap_n_next = '0;
          case (state)
            ST_WRAP_Z: state_next = ST_WRAP_Y;
            ST_WRAP_Y: state_next = ST_WRAP_X;
            default:   state_next = ST_RANGE;
          endcase
        end else begin
          wrap_n_next = wrap_n + 1'b1;
        end
      end
      ST_RANGE: begin
        state_next = status.out_of_range ? ST_IDLE : ST_SQUARE;
      end
      ST_SQUARE: begin
        step_next = step + 1'b1;
        if (step == SQ_Z) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: state_next = ST_COMPARE;
      ST_COMPARE: begin
        state_next = status.in_cutoff ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_WRAP_Z, ST_WRAP_Y, ST_WRAP_X: begin
        case (state)
          ST_WRAP_Z: cmd.axis = AX_Z;
          ST_WRAP_Y: cmd.axis = AX_Y;
          default:   cmd.axis = AX_X;
        endcase
        cmd.correct = !fits_now && !limit;
        cmd.set_ovf = !fits_now && limit;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        cmd.sq_sel = step;
      end
      ST_EMIT: cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      wrap_n <= '0;
      step   <= '0;
    end else begin
      state  <= state_next;
      wrap_n <= wrap_n_next;
      step   <= step_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/ppcf_datapath.sv */
`default_nettype none

module ppcf_datapath #(
  parameter int MAX_ATOMS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ppcf_pkg::cfg_t      cfg,
  input  wire ppcf_pkg::pair_in_t  in_item,
  input  wire ppcf_pkg::cmd_t      cmd,
  output ppcf_pkg::status_t        status,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ppcf_pkg::pair_out_t      out_item
);
  import ppcf_pkg::*;

  localparam logic [24:0] AtomLimit = 25'(MAX_ATOMS);

  logic signed [DW-1:0] dx, dy, dz;
  logic [15:0]          idx_a, idx_b;
  logic                 ovf;
  logic [31:0]          pair_count, count_next;
  logic [DW-1:0]        ax, ay, az;
  logic [DW-1:0]        len_z, len_y, len_x;
  logic signed [DW-1:0] t_xy, t_yz, t_xz;
  logic [30:0]          mul_op;
  logic [61:0]          prod;
  logic                 acc_en;
  logic                 acc_to_cut;
  logic [63:0]          acc;
  logic [61:0]          cut_sq;
  logic [DW-1:0]        cut_w;

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] v);
    mag_of = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic signed [DW-1:0] sext32(input logic [31:0] v);
    sext32 = {{(DW-32){v[31]}}, v};
  endfunction

  assign len_x = {{(DW-31){1'b0}}, cfg.box_x};
  assign len_y = {{(DW-31){1'b0}}, cfg.box_y};
  assign len_z = {{(DW-31){1'b0}}, cfg.box_z};
  assign cut_w = {{(DW-31){1'b0}}, cfg.cutoff};
  assign t_xy  = sext32(cfg.tilt_xy);
  assign t_yz  = sext32(cfg.tilt_yz);
  assign t_xz  = sext32(cfg.tilt_xz);

  assign ax = mag_of(dx);
  assign ay = mag_of(dy);
  assign az = mag_of(dz);

  assign status.pair_ok = (in_item.first_index != in_item.second_index)
                       && ({9'b0, in_item.first_index} < AtomLimit)
                       && ({9'b0, in_item.second_index} < AtomLimit);
  // Half-length test done exactly as 2*|d| <= length
  assign status.fits_z = ({1'b0, az[DW-2:0], 1'b0} <= {1'b0, len_z});
  assign status.fits_y = ({1'b0, ay[DW-2:0], 1'b0} <= {1'b0, len_y});
  assign status.fits_x = ({1'b0, ax[DW-2:0], 1'b0} <= {1'b0, len_x});
  assign status.out_of_range = (ax >= cut_w) || (ay >= cut_w) || (az >= cut_w);
  assign status.in_cutoff = (acc < {2'b0, cut_sq});
  assign status.out_free = !out_valid || !out_stall;

  // Displacement and wrap corrections, one correction per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx    <= sext32(in_item.second_x) - sext32(in_item.first_x);
      dy    <= sext32(in_item.second_y) - sext32(in_item.first_y);
      dz    <= sext32(in_item.second_z) - sext32(in_item.first_z);
      idx_a <= in_item.first_index;
      idx_b <= in_item.second_index;
    end else if (cmd.correct) begin
      case (cmd.axis)
        AX_Z: begin
          if (dz[DW-1]) begin
            dz <= dz + $signed(len_z);
            dy <= dy + t_yz;
            dx <= dx + t_xz;
          end else begin
            dz <= dz - $signed(len_z);
            dy <= dy - t_yz;
            dx <= dx - t_xz;
          end
        end
        AX_Y: begin
          if (dy[DW-1]) begin
            dy <= dy + $signed(len_y);
            dx <= dx + t_xy;
          end else begin
            dy <= dy - $signed(len_y);
            dx <= dx - t_xy;
          end
        end
        default: begin
          dx <= dx[DW-1] ? dx + $signed(len_x) : dx - $signed(len_x);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ovf <= 1'b0;
    end else if (cmd.set_ovf) begin
      ovf <= 1'b1;
    end
  end

  // Shared squarer: cutoff, then x, y, z; product registered before the add
  always_comb begin
    case (cmd.sq_sel)
      SQ_CUT:  mul_op = cfg.cutoff;
      SQ_X:    mul_op = ax[30:0];
      SQ_Y:    mul_op = ay[30:0];
      SQ_Z:    mul_op = az[30:0];
      default: mul_op = cfg.cutoff;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      prod       <= 62'(mul_op) * 62'(mul_op);
      acc_to_cut <= (cmd.sq_sel == SQ_CUT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.square;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (acc_en) begin
      if (acc_to_cut) begin
        cut_sq <= prod;
      end else begin
        acc <= acc + {2'b0, prod};
      end
    end
  end

  // Saturating pair counter and output register
  assign count_next = (pair_count == '1) ? pair_count : pair_count + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load && in_item.restart_count) begin
        pair_count <= '0;
      end else if (cmd.emit) begin
        pair_count <= count_next;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.pair_first    <= idx_a;
      out_item.pair_second   <= idx_b;
      out_item.pair_ordinal  <= count_next;
      out_item.wrap_overflow <= ovf;
    end
  end

endmodule

`default_nettype wire

/* hdl/periodic_pair_cutoff_filter.sv */
// Periodic pair cutoff filter: minimum-image distance test for atom pairs
// in a triclinic box.
// Input channel (in_valid / in_stall / in_item): one candidate pair per item,
// accepted when in_valid is high and in_stall is low. in_stall is high while
// an item is in work; one item is processed at a time.
// Output channel (out_valid / out_stall / out_item): zero or one result per
// item, for pairs within the cutoff, numbered by a saturating counter.
// Sequence: an item with equal or out-of-range indices is dropped when taken.
// Otherwise a load, then per axis (z, y, x) one wrap correction per cycle
// until a fit check passes or WRAP_LIMIT corrections are made, a range
// check (a pair with an axis at or past the cutoff ends here), the squares
// of the cutoff and of x, y and z on the shared 31x31 squarer, a settle and
// a compare (a pair at or outside the cutoff ends here), and a hand-off to
// the output register. The number of wrap corrections varies per item.
// The output register holds a finished result while out_stall is high; the
// next item is taken meanwhile and waits only at its own hand-off.
// Configuration (cfg_write / cfg_index / cfg_data) must be written only while idle; the block does not enforce this.
// Reset (rst, synchronous) restores box lengths of 1.0, zero tilts, a zero
// cutoff, clears the pair counter and drops any pending result.
`default_nettype none

module periodic_pair_cutoff_filter #(
  parameter int MAX_ATOMS  = 65536,
  parameter int WRAP_LIMIT = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ppcf_pkg::pair_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ppcf_pkg::pair_out_t      out_item,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import ppcf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers; a write to an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x   <= 31'd65536;
      cfg.box_y   <= 31'd65536;
      cfg.box_z   <= 31'd65536;
      cfg.tilt_xy <= '0;
      cfg.tilt_yz <= '0;
      cfg.tilt_xz <= '0;
      cfg.cutoff  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BOX_X:   cfg.box_x   <= cfg_data[30:0];
        CFG_BOX_Y:   cfg.box_y   <= cfg_data[30:0];
        CFG_BOX_Z:   cfg.box_z   <= cfg_data[30:0];
        CFG_TILT_XY: cfg.tilt_xy <= cfg_data;
        CFG_TILT_YZ: cfg.tilt_yz <= cfg_data;
        CFG_TILT_XZ: cfg.tilt_xz <= cfg_data;
        CFG_CUTOFF:  cfg.cutoff  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer: steps the wrap, range, squaring and hand-off phases
  ppcf_ctrl #(
    .WRAP_LIMIT(WRAP_LIMIT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Displacement registers, wrap adders, squarer, counter and output register
  ppcf_datapath #(
    .MAX_ATOMS(MAX_ATOMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* hdl/ppcf_checker.sv */
`default_nettype none

module ppcf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire ppcf_pkg::pair_in_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ppcf_pkg::pair_out_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // Hold an offered item until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed or dropped");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A pair with equal indices never comes out
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pair_first != out_item.pair_second)
    else $error("result with equal indices");

  // Ordinals start at one
  a_ordinal_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pair_ordinal != 32'd0)
    else $error("result with zero ordinal");

endmodule

bind periodic_pair_cutoff_filter ppcf_checker u_ppcf_checker (.*);

`default_nettype wire
